[design/lpht_pkg.sv]
// Shared types and constants for the linear-probe hash table.
// Used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package lpht_pkg;

  // Fixed field widths of the request and response beats
  localparam int KIND_W        = 2;
  localparam int KEY_FIELD_W   = 16;
  localparam int STATUS_W      = 3;
  localparam int SLOT_FIELD_W  = 4;
  localparam int TOTAL_FIELD_W = 5;

  // Request kinds; the fourth code is unused and answers not found
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5
  } status_t;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR_WRITE,  // write an empty entry at ptr, advance ptr
    DP_LATCH,      // capture request, start home computation
    DP_PROBE_INIT, // ptr = home, probe count = 0
    DP_READ,       // read entry at ptr
    DP_READ_NX,    // read entry at walk pointer
    DP_STEP,       // advance ptr, count the probe
    DP_WRITE_KEY,  // store request key at ptr, count up
    DP_DEL,        // empty entry at ptr, remember it, start walk
    DP_MOD_MOVED,  // capture walked key, start its home computation
    DP_NX_STEP,    // advance walk pointer
    DP_EVICT,      // empty entry at walk pointer, ptr = home of moved key
    DP_PLACE       // store moved key at ptr, advance walk pointer
  } dp_op_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_PTR
  } slot_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_FIND_RD,
    S_FIND_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_MOVE_HOME,
    S_PLACE_RD,
    S_PLACE_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t    op;
    logic      set_res;
    status_t   res_code;
    slot_sel_t slot_sel;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic              mod_done;
    logic              home_eq_nx;
    logic              rd_valid;
    logic              rd_match;
    logic              probe_last;
    logic              nx_is_s;
    logic              full;
    logic              clr_last;
    logic              out_busy;
    logic [KIND_W-1:0] kind;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/lpht_if.sv]
// Request and response channel interfaces, valid/ready handshake.
// Field widths come from lpht_pkg.
`default_nettype none

interface lpht_req_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::KIND_W-1:0]     kind;
  logic [lpht_pkg::KEY_FIELD_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface lpht_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [lpht_pkg::STATUS_W-1:0]     status;
  logic [lpht_pkg::SLOT_FIELD_W-1:0] slot_index;
  logic [lpht_pkg::TOTAL_FIELD_W-1:0] entry_total;

  modport source (output valid, output status, output slot_index, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input entry_total,
                  output ready);
endinterface

`default_nettype wire

[design/lpht_mod.sv]
// Home slot unit: key modulo TABLE_SIZE by reciprocal multiplication.
// Operand, product, raw and final remainder registers; the datapath uses it.
`default_nettype none

module lpht_mod #(
  parameter int KEY_BITS   = 16,
  parameter int TABLE_SIZE = 16,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [KEY_BITS-1:0] operand,
  output logic                     done,
  output logic [IDX_W-1:0]         rem
);

  // Stored keys never carry more bits than the request field
  localparam int XW = lpht_pkg::KEY_FIELD_W;
  localparam int PW = 2 * XW;
  localparam logic [XW-1:0] RECIP   = XW'((1 << XW) / TABLE_SIZE);
  localparam logic [XW-1:0] MODULUS = XW'(TABLE_SIZE);
  localparam logic [1:0]    STAGES  = 2'd3;

  logic [KEY_BITS+XW-1:0] op_ext;
  logic [XW-1:0]          x_r, x_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [PW-1:0]          qm;
  logic [XW-1:0]          raw_r, raw_nxt;
  logic [XW-1:0]          fix;
  logic [IDX_W-1:0]       rem_r, rem_nxt;
  logic [1:0]             left_r, left_nxt;

  assign op_ext = {{XW{1'b0}}, operand};

  // Estimate the quotient low by at most one, take the remainder, correct once
  always_comb begin
    x_nxt    = start ? op_ext[XW-1:0] : x_r;
    prod_nxt = PW'(x_r) * PW'(RECIP);
    qm       = PW'(prod_r[PW-1:XW]) * PW'(MODULUS);
    raw_nxt  = x_r - qm[XW-1:0];
    fix      = (raw_r >= MODULUS) ? (raw_r - MODULUS) : raw_r;
    rem_nxt  = fix[IDX_W-1:0];
  end

  // Count the stages until the remainder settles
  always_comb begin
    left_nxt = left_r;
    if (start) begin
      left_nxt = STAGES;
    end else if (left_r != '0) begin
      left_nxt = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    raw_r  <= raw_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = (left_r == '0);
  assign rem  = rem_r;

endmodule

`default_nettype wire

[design/lpht_dp.sv]
// Datapath: slot memory, probe and walk pointers, entry count, result register.
// Depends on lpht_pkg, lpht_if and lpht_mod; driven by lpht_ctrl commands.
`default_nettype none

module lpht_dp #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16,
  localparam int IDX_W     = $clog2(TABLE_SIZE),
  localparam int CNT_W     = $clog2(TABLE_SIZE + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [lpht_pkg::KIND_W-1:0]          in_kind,
  input  wire logic [lpht_pkg::KEY_FIELD_W-1:0]     in_key,
  input  wire lpht_pkg::dp_cmd_t                    cmd,
  output lpht_pkg::dp_stat_t                        stat,
  lpht_rsp_if.source                                out_rsp
);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

  // Request key masked or widened to KEY_BITS
  logic [KEY_BITS+lpht_pkg::KEY_FIELD_W-1:0] key_ext;
  logic [KEY_BITS-1:0]                       in_key_m;
  assign key_ext  = {{KEY_BITS{1'b0}}, in_key};
  assign in_key_m = key_ext[KEY_BITS-1:0];

  logic [lpht_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [KEY_BITS-1:0]         moved_r, moved_nxt;
  logic [IDX_W-1:0]            ptr_r, ptr_nxt;
  logic [IDX_W-1:0]            nx_r, nx_nxt;
  logic [IDX_W-1:0]            s_r, s_nxt;
  logic [IDX_W-1:0]            n_r, n_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  lpht_pkg::status_t           res_code_r, res_code_nxt;
  logic [IDX_W-1:0]            res_slot_r, res_slot_nxt;

  logic [IDX_W-1:0] ptr_inc;
  logic [IDX_W-1:0] nx_inc;
  assign ptr_inc = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign nx_inc  = (nx_r == LAST_SLOT) ? '0 : nx_r + 1'b1;

  // Slot memory: {valid, key} per entry, registered read
  logic [KEY_BITS:0]   mem [TABLE_SIZE];
  logic [KEY_BITS:0]   rd_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KEY_BITS:0]   mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  assign rd_valid = rd_r[KEY_BITS];
  assign rd_key   = rd_r[KEY_BITS-1:0];

  // Home slot unit
  logic                mod_start;
  logic [KEY_BITS-1:0] mod_operand;
  logic                mod_done;
  logic [IDX_W-1:0]    home;

  lpht_mod #(
    .KEY_BITS   (KEY_BITS),
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .operand (mod_operand),
    .done    (mod_done),
    .rem     (home)
  );

  // Decode the operation into register and memory updates
  always_comb begin
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    moved_nxt   = moved_r;
    ptr_nxt     = ptr_r;
    nx_nxt      = nx_r;
    s_nxt       = s_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    mem_waddr   = ptr_r;
    mem_wdata   = {1'b0, key_r};
    mem_re      = 1'b0;
    mem_raddr   = ptr_r;
    mod_start   = 1'b0;
    mod_operand = in_key_m;
    unique case (cmd.op)
      lpht_pkg::DP_NOP: begin
      end
      lpht_pkg::DP_CLR_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_nxt   = ptr_inc;
      end
      lpht_pkg::DP_LATCH: begin
        kind_nxt  = in_kind;
        key_nxt   = in_key_m;
        mod_start = 1'b1;
      end
      lpht_pkg::DP_PROBE_INIT: begin
        ptr_nxt = home;
        n_nxt   = '0;
      end
      lpht_pkg::DP_READ: begin
        mem_re = 1'b1;
      end
      lpht_pkg::DP_READ_NX: begin
        mem_re    = 1'b1;
        mem_raddr = nx_r;
      end
      lpht_pkg::DP_STEP: begin
        ptr_nxt = ptr_inc;
        n_nxt   = n_r + 1'b1;
      end
      lpht_pkg::DP_WRITE_KEY: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, key_r};
        cnt_nxt   = cnt_r + 1'b1;
      end
      lpht_pkg::DP_DEL: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        s_nxt     = ptr_r;
        nx_nxt    = ptr_inc;
        cnt_nxt   = cnt_r - 1'b1;
      end
      lpht_pkg::DP_MOD_MOVED: begin
        moved_nxt   = rd_key;
        mod_start   = 1'b1;
        mod_operand = rd_key;
      end
      lpht_pkg::DP_NX_STEP: begin
        nx_nxt = nx_inc;
      end
      lpht_pkg::DP_EVICT: begin
        mem_we    = 1'b1;
        mem_waddr = nx_r;
        mem_wdata = '0;
        ptr_nxt   = home;
      end
      lpht_pkg::DP_PLACE: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, moved_r};
        nx_nxt    = nx_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  // Capture the result code and slot for the pending beat
  always_comb begin
    res_code_nxt = res_code_r;
    res_slot_nxt = res_slot_r;
    if (cmd.set_res) begin
      res_code_nxt = cmd.res_code;
      unique case (cmd.slot_sel)
        lpht_pkg::SLOT_PTR:  res_slot_nxt = ptr_r;
        lpht_pkg::SLOT_ZERO: res_slot_nxt = '0;
        default:             res_slot_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    moved_r    <= moved_nxt;
    nx_r       <= nx_nxt;
    s_r        <= s_nxt;
    n_r        <= n_nxt;
    res_code_r <= res_code_nxt;
    res_slot_r <= res_slot_nxt;
  end

  // Output register: holds a finished beat while the sink stalls
  logic                                  out_valid_r, out_valid_nxt;
  logic [lpht_pkg::STATUS_W-1:0]         out_status_r;
  logic [lpht_pkg::SLOT_FIELD_W-1:0]     out_slot_r;
  logic [lpht_pkg::TOTAL_FIELD_W-1:0]    out_total_r;
  logic [IDX_W+lpht_pkg::SLOT_FIELD_W-1:0]  slot_ext;
  logic [CNT_W+lpht_pkg::TOTAL_FIELD_W-1:0] total_ext;

  assign slot_ext  = {{lpht_pkg::SLOT_FIELD_W{1'b0}}, res_slot_r};
  assign total_ext = {{lpht_pkg::TOTAL_FIELD_W{1'b0}}, cnt_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_code_r;
      out_slot_r   <= slot_ext[lpht_pkg::SLOT_FIELD_W-1:0];
      out_total_r  <= total_ext[lpht_pkg::TOTAL_FIELD_W-1:0];
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.slot_index  = out_slot_r;
  assign out_rsp.entry_total = out_total_r;

  // Status back to the controller
  always_comb begin
    stat.mod_done   = mod_done;
    stat.home_eq_nx = (home == nx_r);
    stat.rd_valid   = rd_valid;
    stat.rd_match   = (rd_key == key_r);
    stat.probe_last = (n_r == LAST_SLOT);
    stat.nx_is_s    = (nx_r == s_r);
    stat.full       = (cnt_r == CNT_W'(TABLE_SIZE));
    stat.clr_last   = (ptr_r == LAST_SLOT);
    stat.out_busy   = out_valid_r && !out_rsp.ready;
    stat.kind       = kind_r;
  end

endmodule

`default_nettype wire

[design/lpht_ctrl.sv]
// Controller state machine: sequences clearing, probing and the delete walk.
// Depends on lpht_pkg; commands the datapath through dp_cmd_t / dp_stat_t.
`default_nettype none

module lpht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lpht_pkg::dp_stat_t stat,
  output lpht_pkg::dp_cmd_t       cmd
);

  lpht_pkg::state_t state_r, state_nxt;

  logic is_ins;
  logic is_del;
  logic is_srch;
  assign is_ins  = (stat.kind == lpht_pkg::KIND_INSERT);
  assign is_del  = (stat.kind == lpht_pkg::KIND_DELETE);
  assign is_srch = (stat.kind == lpht_pkg::KIND_SEARCH);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lpht_pkg::S_HOME;
      end
      lpht_pkg::S_HOME: begin
        if (stat.mod_done) begin
          priority if (is_ins && stat.full)         state_nxt = lpht_pkg::S_FINISH;
          else if (is_ins || is_del || is_srch)     state_nxt = lpht_pkg::S_FIND_RD;
          else                                      state_nxt = lpht_pkg::S_FINISH;
        end
      end
      lpht_pkg::S_FIND_RD: state_nxt = lpht_pkg::S_FIND_CHK;
      lpht_pkg::S_FIND_CHK: begin
        priority if (!stat.rd_valid)        state_nxt = lpht_pkg::S_FINISH;
        else if (stat.rd_match && is_del)   state_nxt = lpht_pkg::S_WALK_RD;
        else if (stat.rd_match)             state_nxt = lpht_pkg::S_FINISH;
        else if (stat.probe_last)           state_nxt = lpht_pkg::S_FINISH;
        else                                state_nxt = lpht_pkg::S_FIND_RD;
      end
      lpht_pkg::S_WALK_RD: begin
        state_nxt = stat.nx_is_s ? lpht_pkg::S_FINISH : lpht_pkg::S_WALK_CHK;
      end
      lpht_pkg::S_WALK_CHK: begin
        state_nxt = stat.rd_valid ? lpht_pkg::S_MOVE_HOME : lpht_pkg::S_FINISH;
      end
      lpht_pkg::S_MOVE_HOME: begin
        if (stat.mod_done) begin
          state_nxt = stat.home_eq_nx ? lpht_pkg::S_WALK_RD : lpht_pkg::S_PLACE_RD;
        end
      end
      lpht_pkg::S_PLACE_RD: state_nxt = lpht_pkg::S_PLACE_CHK;
      lpht_pkg::S_PLACE_CHK: begin
        state_nxt = stat.rd_valid ? lpht_pkg::S_PLACE_RD : lpht_pkg::S_WALK_RD;
      end
      lpht_pkg::S_FINISH: begin
        if (!stat.out_busy) state_nxt = lpht_pkg::S_IDLE;
      end
      default: state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = lpht_pkg::DP_NOP;
    cmd.set_res  = 1'b0;
    cmd.res_code = lpht_pkg::ST_NOT_FOUND;
    cmd.slot_sel = lpht_pkg::SLOT_ZERO;
    cmd.out_load = 1'b0;
    unique case (state_r)
      lpht_pkg::S_CLEAR: cmd.op = lpht_pkg::DP_CLR_WRITE;
      lpht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = lpht_pkg::DP_LATCH;
      end
      lpht_pkg::S_HOME: begin
        if (stat.mod_done) begin
          priority if (is_ins && stat.full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = lpht_pkg::ST_FULL;
          end else if (is_ins || is_del || is_srch) begin
            cmd.op = lpht_pkg::DP_PROBE_INIT;
          end else begin
            // unused kind code: no change
            cmd.set_res  = 1'b1;
            cmd.res_code = lpht_pkg::ST_NOT_FOUND;
          end
        end
      end
      lpht_pkg::S_FIND_RD: cmd.op = lpht_pkg::DP_READ;
      lpht_pkg::S_FIND_CHK: begin
        priority if (!stat.rd_valid) begin
          // empty slot ends the probe; insert takes it
          cmd.set_res = 1'b1;
          if (is_ins) begin
            cmd.op       = lpht_pkg::DP_WRITE_KEY;
            cmd.res_code = lpht_pkg::ST_INSERTED;
            cmd.slot_sel = lpht_pkg::SLOT_PTR;
          end
        end else if (stat.rd_match) begin
          cmd.set_res  = 1'b1;
          cmd.slot_sel = lpht_pkg::SLOT_PTR;
          priority if (is_del) begin
            cmd.op       = lpht_pkg::DP_DEL;
            cmd.res_code = lpht_pkg::ST_DELETED;
          end else if (is_ins) begin
            cmd.res_code = lpht_pkg::ST_PRESENT;
          end else begin
            cmd.res_code = lpht_pkg::ST_FOUND;
          end
        end else if (stat.probe_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = is_ins ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
        end else begin
          cmd.op = lpht_pkg::DP_STEP;
        end
      end
      lpht_pkg::S_WALK_RD: begin
        if (!stat.nx_is_s) cmd.op = lpht_pkg::DP_READ_NX;
      end
      lpht_pkg::S_WALK_CHK: begin
        if (stat.rd_valid) cmd.op = lpht_pkg::DP_MOD_MOVED;
      end
      lpht_pkg::S_MOVE_HOME: begin
        if (stat.mod_done) begin
          cmd.op = stat.home_eq_nx ? lpht_pkg::DP_NX_STEP : lpht_pkg::DP_EVICT;
        end
      end
      lpht_pkg::S_PLACE_RD: cmd.op = lpht_pkg::DP_READ;
      lpht_pkg::S_PLACE_CHK: begin
        cmd.op = stat.rd_valid ? lpht_pkg::DP_STEP : lpht_pkg::DP_PLACE;
      end
      lpht_pkg::S_FINISH: begin
        if (!stat.out_busy) cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/linear_probe_hash_table_top.sv]
// Top level of the linear-probe hash table: controller plus datapath.
// Depends on lpht_pkg, lpht_if, lpht_ctrl and lpht_dp.
`default_nettype none

// Open-addressing hash table with linear probing over TABLE_SIZE slots of
// KEY_BITS-bit keys; the home slot is key modulo TABLE_SIZE. Each request
// beat (insert, delete, search) returns exactly one response beat. After
// reset a clearing pass empties the slot memory, with in_req.ready low. One
// request is worked at a time. The home slot comes from a reciprocal-multiply
// remainder unit with operand, product, raw remainder and remainder
// registers, and each probe is a read, then a check, on the slot memory. A
// full-table insert or the unused kind code answers without probing. A
// delete additionally walks the cluster behind the freed slot: each walked
// entry is read, checked and its home computed; when it is moved, its new
// slot is found by probing from that home, and the walk ends on the freed
// or an empty slot. A response beat waiting in the output register does
// not block the next request.
module linear_probe_hash_table_top #(
  parameter int TABLE_SIZE = 16,
  parameter int KEY_BITS   = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  lpht_req_if.sink   in_req,
  lpht_rsp_if.source out_rsp
);

  lpht_pkg::dp_cmd_t  cmd;
  lpht_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_req.ready = in_ready;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_kind (in_req.kind),
    .in_key  (in_req.key),
    .cmd     (cmd),
    .stat    (stat),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire
